@@ sv/assert_macros.svh @@
// Assertion macros used by the min-heap RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

@@ sv/mhp_pkg.sv @@
// ----------------------------------------------------------------------------
// mhp_pkg
// Shared types and codes for the min-heap block.
// ----------------------------------------------------------------------------
package mhp_pkg;
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_LAST_RD,
        S_PAR_RD,
        S_PAR_CMP,
        S_DN_RD_L,
        S_DN_RD_R,
        S_DN_CMP,
        S_ROOT_RD,
        S_ROOT_WAIT,
        S_DONE
    } fsm_t;
endpackage

@@ sv/min_heap_insert_remove_by_value.sv @@
// ----------------------------------------------------------------------------
// min_heap_insert_remove_by_value
// Binary min-heap of signed keys in a single-port store: insert and
// remove-by-value, each returning status, count and minimum.
// ----------------------------------------------------------------------------
// channel | direction | ports
// s_      | in        | s_valid s_ready s_req_type s_value
// m_      | out       | m_valid m_ready m_status m_count m_min_valid m_min_value
//
// One request at a time; one store access per cycle, with registered read data.
// Insert: the new key is sifted up level by level, then the root is read for
// the result.
// Remove: entries are scanned in order (up to the count), the last entry is
// fetched, then sifted up or down level by level, then the root is read.
// Reset clears the count and returns the FSM to idle; the store needs no clearing pass.
// s_ready is low while a request is in work or its result is unaccepted.
`include "assert_macros.svh"
module min_heap_insert_remove_by_value #(
    parameter int CAPACITY  = 1024,
    parameter int KEY_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic signed [31:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [10:0] m_count,
    output logic        m_min_valid,
    output logic signed [31:0] m_min_value
);
    import mhp_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [KEY_WIDTH-1:0] SIGN = {1'b1, {(KEY_WIDTH-1){1'b0}}};

    // key store
    logic [KEY_WIDTH-1:0] mem [CAPACITY];
    logic [KEY_WIDTH-1:0] rd_data;
    logic                 we;
    logic [AW-1:0]        addr;
    logic [KEY_WIDTH-1:0] wdata;

    always_ff @(posedge aclk) begin
        if (we) mem[addr] <= wdata;
        rd_data <= mem[addr];
    end

    fsm_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;    // moving / searched key
    logic [KEY_WIDTH-1:0] lv_reg, lv_next;      // left child value
    logic                 lok_reg, lok_next;
    logic [1:0]  st_reg, st_next;
    logic [KEY_WIDTH-1:0] root_reg, root_next;

    logic [CW-1:0] par, lch, rch;
    logic [CW:0]   lw, rw;
    logic [KEY_WIDTH-1:0] in_key;

    always_comb begin
        par = (pos_reg - CW'(1)) >> 1;
        lw  = {pos_reg, 1'b1};
        rw  = lw + (CW+1)'(1);
        lch = lw[CW-1:0];
        rch = rw[CW-1:0];
        in_key = s_value[KEY_WIDTH-1:0] ^ SIGN;
    end

    // next state and datapath
    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg; pos_next = pos_reg; key_next = key_reg;
        lv_next = lv_reg; lok_next = lok_reg; st_next = st_reg;
        root_next = root_reg;
        we = 1'b0; addr = pos_reg[AW-1:0]; wdata = key_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    key_next = in_key;
                    st_next  = ST_OK;
                    if (s_req_type == REQ_INSERT) begin
                        if (cnt_reg >= CW'(CAPACITY)) begin
                            st_next = ST_FULL; state_next = S_ROOT_RD;
                        end else begin
                            pos_next = cnt_reg;
                            cnt_next = cnt_reg + CW'(1);
                            state_next = S_UP_RD;
                        end
                    end else begin
                        pos_next = '0;
                        state_next = S_SCAN_RD;
                    end
                end
            end
            // sift up: key_reg belongs at pos_reg
            S_UP_RD: begin
                if (pos_reg == '0) begin
                    we = 1'b1; state_next = S_ROOT_RD;
                end else begin
                    addr = par[AW-1:0]; state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (key_reg < rd_data) begin
                    we = 1'b1; wdata = rd_data;
                    pos_next = par; state_next = S_UP_RD;
                end else begin
                    we = 1'b1; state_next = S_ROOT_RD;
                end
            end
            // linear scan
            S_SCAN_RD: begin
                if (pos_reg >= cnt_reg) begin
                    st_next = ST_NOT_FOUND; state_next = S_ROOT_RD;
                end else state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (rd_data == key_reg) begin
                    addr = AW'(cnt_reg - CW'(1));
                    cnt_next = cnt_reg - CW'(1);
                    state_next = S_LAST_RD;
                end else begin
                    pos_next = pos_reg + CW'(1);
                    addr = AW'(pos_reg + CW'(1));
                    state_next = S_SCAN_RD;
                end
            end
            S_LAST_RD: begin
                key_next = rd_data;
                if (pos_reg >= cnt_reg) state_next = S_ROOT_RD;
                else if (pos_reg == '0) state_next = S_DN_RD_L;
                else begin
                    addr = par[AW-1:0]; state_next = S_PAR_CMP;
                end
            end
            S_PAR_CMP: begin
                if (key_reg < rd_data) begin
                    we = 1'b1; wdata = rd_data;
                    pos_next = par; state_next = S_UP_RD;
                end else state_next = S_DN_RD_L;
            end
            // sift down: read children
            S_DN_RD_L: begin
                addr = lch[AW-1:0];
                lok_next = (lw < {1'b0, cnt_reg});
                state_next = S_DN_RD_R;
            end
            S_DN_RD_R: begin
                lv_next = rd_data;
                addr = rch[AW-1:0];
                state_next = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (rw < {1'b0, cnt_reg} && rd_data < key_reg &&
                    !(lok_reg && lv_reg <= rd_data)) begin
                    we = 1'b1; wdata = rd_data;
                    pos_next = rch; state_next = S_DN_RD_L;
                end else if (lok_reg && lv_reg < key_reg) begin
                    we = 1'b1; wdata = lv_reg;
                    pos_next = lch; state_next = S_DN_RD_L;
                end else begin
                    we = 1'b1; state_next = S_ROOT_RD;
                end
            end
            S_ROOT_RD: begin
                addr = '0; state_next = S_ROOT_WAIT;
            end
            S_ROOT_WAIT: begin
                root_next = rd_data; state_next = S_DONE;
            end
            S_DONE: begin
                if (m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready = (state_reg == S_IDLE);
        m_valid = (state_reg == S_DONE);
        m_status = st_reg;
        m_count = 11'(cnt_reg);
        m_min_valid = (cnt_reg != '0);
        m_min_value = (cnt_reg != '0) ? 32'(signed'(root_reg ^ SIGN)) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
        pos_reg <= pos_next; key_reg <= key_next; lv_reg <= lv_next;
        lok_reg <= lok_next; st_reg <= st_next; root_reg <= root_next;
    end

    `ASSERT_IMPLIES(a_cnt_max, aclk, aresetn, 1'b1, cnt_reg <= CW'(CAPACITY), "count over capacity")
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_count), "result dropped")
    `ASSERT_IMPLIES(a_excl, aclk, aresetn, 1'b1, !(s_ready && m_valid), "ready while result pending")
    `ASSERT_NEXT(a_full, aclk, aresetn, s_valid && s_ready && s_req_type == REQ_INSERT && cnt_reg == CW'(CAPACITY), $stable(cnt_reg), "insert into full heap changed count")
endmodule

@@ tb/sv/min_heap_insert_remove_by_value_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_heap_insert_remove_by_value_tb
// Drives insert and remove-by-value requests into the min-heap and checks
// each response against a heap kept inside the bench. Covers empty heap,
// duplicate and sign-extreme keys, and removes that sift up as well as down.
// ----------------------------------------------------------------------------
module min_heap_insert_remove_by_value_tb;
    import mhp_pkg::*;

    localparam int CAPACITY = 1024;
    localparam logic [31:0] SIGN_FLIP = 32'h8000_0000;

    typedef struct {
        logic               req_type;
        logic signed [31:0] value;
        bit                 drain;    // hold until all responses are back
    } request_t;

    typedef struct {
        status_t            status;
        logic [10:0]        count;
        logic               min_valid;
        logic signed [31:0] min_value;
    } response_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_req_type = REQ_INSERT;
    logic signed [31:0] s_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_status;
    logic [10:0]        m_count;
    logic               m_min_valid;
    logic signed [31:0] m_min_value;

    request_t  pending_reqs[$];
    response_t expected_resps[$];
    int        errors = 0;

    // Bench copy of the heap: keys stored sign-flipped for unsigned compare
    logic [31:0] heap_keys [CAPACITY];
    int          heap_size = 0;

    int burst_left = 0;
    int gap_left = 0;
    int cycle_cnt = 0;

    min_heap_insert_remove_by_value DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_count     (m_count),
        .m_min_valid (m_min_valid),
        .m_min_value (m_min_value)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic swap_keys(input int a, input int b);
        logic [31:0] t;
        t = heap_keys[a];
        heap_keys[a] = heap_keys[b];
        heap_keys[b] = t;
    endtask

    task automatic heap_sift_up(input int pos);
        int up;
        while (pos > 0) begin
            up = (pos - 1) / 2;
            if (heap_keys[pos] < heap_keys[up]) begin
                swap_keys(pos, up);
                pos = up;
            end else begin
                break;
            end
        end
    endtask

    task automatic heap_sift_down(input int pos);
        int l, r, best;
        forever begin
            l = 2 * pos + 1;
            r = 2 * pos + 2;
            best = pos;
            if (l < heap_size && heap_keys[l] < heap_keys[best]) best = l;
            if (r < heap_size && heap_keys[r] < heap_keys[best]) best = r;
            if (best == pos) break;
            swap_keys(pos, best);
            pos = best;
        end
    endtask

    // Apply one request to the bench heap and queue the response it implies
    task automatic apply_heap_request(input logic req_type, input logic signed [31:0] value);
        logic [31:0] key;
        response_t   resp;
        int          pos;
        key = value ^ SIGN_FLIP;
        pos = -1;
        resp.status = ST_OK;
        if (req_type == REQ_INSERT) begin
            if (heap_size >= CAPACITY) begin
                resp.status = ST_FULL;
            end else begin
                heap_keys[heap_size] = key;
                heap_sift_up(heap_size);
                heap_size++;
            end
        end else begin
            for (int i = 0; i < heap_size; i++) begin
                if (heap_keys[i] == key) begin
                    pos = i;
                    break;
                end
            end
            if (pos < 0) begin
                resp.status = ST_NOT_FOUND;
            end else begin
                heap_keys[pos] = heap_keys[heap_size - 1];
                heap_size--;
                if (pos < heap_size) begin
                    if (pos > 0 && heap_keys[pos] < heap_keys[(pos - 1) / 2])
                        heap_sift_up(pos);
                    else
                        heap_sift_down(pos);
                end
            end
        end
        resp.count = heap_size[10:0];
        resp.min_valid = (heap_size > 0);
        resp.min_value = (heap_size > 0) ? (heap_keys[0] ^ SIGN_FLIP) : '0;
        expected_resps.push_back(resp);
    endtask

    // Driver: bursts with random gaps, one item per transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) apply_heap_request(s_req_type, s_value);
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() > 0 &&
                             !(pending_reqs[0].drain && expected_resps.size() > 0)) begin
                    s_valid    <= 1'b1;
                    s_req_type <= pending_reqs[0].req_type;
                    s_value    <= pending_reqs[0].value;
                    void'(pending_reqs.pop_front());
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 20);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: receiver stall pattern rotates through four patterns over the run
    always @(posedge aclk) begin
        cycle_cnt++;
        case ((cycle_cnt >> 7) % 4)
            0: m_ready <= 1'b1;
            1: m_ready <= $urandom_range(0, 1);
            2: m_ready <= (cycle_cnt % 4 == 0);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
        if (aresetn && m_valid && m_ready) begin
            if (expected_resps.size() == 0) begin
                $error("response with no request outstanding");
                errors++;
            end else begin
                if (m_status !== expected_resps[0].status) begin
                    $error("status: expected %0d, got %0d", expected_resps[0].status, m_status);
                    errors++;
                end
                if (m_count !== expected_resps[0].count) begin
                    $error("count: expected %0d, got %0d", expected_resps[0].count, m_count);
                    errors++;
                end
                if (m_min_valid !== expected_resps[0].min_valid) begin
                    $error("min_valid: expected %0b, got %0b",
                           expected_resps[0].min_valid, m_min_valid);
                    errors++;
                end
                if (m_min_value !== expected_resps[0].min_value) begin
                    $error("min_value: expected %0d, got %0d",
                           expected_resps[0].min_value, m_min_value);
                    errors++;
                end
                void'(expected_resps.pop_front());
            end
        end
    end

    // Stimulus generation; held_vals tracks what the heap should contain
    int held_vals[$];

    task automatic queue_req(input logic req_type, input logic signed [31:0] value,
                             input bit drain = 0);
        request_t r;
        int idx[$];
        r.req_type = req_type;
        r.value = value;
        r.drain = drain;
        pending_reqs.push_back(r);
        if (req_type == REQ_INSERT) begin
            if (held_vals.size() < CAPACITY) held_vals.push_back(value);
        end else begin
            idx = held_vals.find_first_index(x) with (x == value);
            if (idx.size() > 0) held_vals.delete(idx[0]);
        end
    endtask

    function automatic logic signed [31:0] random_key();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $signed($urandom_range(0, 15)) - 8;
            3: return $signed($urandom_range(0, 200)) - 100;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_random_remove();
        if (held_vals.size() > 0 && $urandom_range(0, 9) < 7)
            queue_req(REQ_REMOVE, held_vals[$urandom_range(0, held_vals.size() - 1)]);
        else
            queue_req(REQ_REMOVE, random_key());
    endtask

    initial begin
        // Directed: empty heap, extremes, duplicates, sift-up on remove
        queue_req(REQ_REMOVE, 0);
        queue_req(REQ_INSERT, 32'sh7FFF_FFFF);
        queue_req(REQ_INSERT, 32'sh8000_0000);
        queue_req(REQ_INSERT, -1);
        queue_req(REQ_INSERT, 0);
        queue_req(REQ_INSERT, 0);
        queue_req(REQ_REMOVE, 12345);
        queue_req(REQ_REMOVE, 32'sh8000_0000);
        queue_req(REQ_REMOVE, 0);
        queue_req(REQ_REMOVE, 0);
        queue_req(REQ_REMOVE, -1);
        queue_req(REQ_REMOVE, 32'sh7FFF_FFFF);
        // Heap 0,100,1,101,102,2,3: removing 101 moves 3 under 100, sifts up
        queue_req(REQ_INSERT, 0);
        queue_req(REQ_INSERT, 100);
        queue_req(REQ_INSERT, 1);
        queue_req(REQ_INSERT, 101);
        queue_req(REQ_INSERT, 102);
        queue_req(REQ_INSERT, 2);
        queue_req(REQ_INSERT, 3);
        queue_req(REQ_REMOVE, 101);
        queue_req(REQ_REMOVE, 0);
        queue_req(REQ_REMOVE, 3);

        // Random mix, heap kept mostly small
        for (int n = 0; n < 500; n++) begin
            if (n == 250) queue_req(REQ_INSERT, random_key(), 1);
            else if (held_vals.size() > 40 ? ($urandom_range(0, 2) != 0)
                                           : ($urandom_range(0, 2) == 0))
                queue_random_remove();
            else
                queue_req(REQ_INSERT, random_key());
        end

        // Eight more removes, the last held value, then an insert of the most negative key
        for (int n = 0; n < 8; n++) queue_random_remove();
        if (held_vals.size() > 0) queue_req(REQ_REMOVE, held_vals[held_vals.size() - 1]);
        queue_req(REQ_INSERT, 32'sh8000_0000);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        wait (pending_reqs.size() == 0 && !s_valid && expected_resps.size() == 0);
        repeat (100) @(posedge aclk);
        if (expected_resps.size() > 0) errors++;
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #100_000_000;
        $display("FAIL");
        $finish;
    end
endmodule

@@ min_heap_insert_remove_by_value.f @@
+incdir+sv
sv/mhp_pkg.sv
sv/min_heap_insert_remove_by_value.sv
tb/sv/min_heap_insert_remove_by_value_tb.sv
